/* hw/rtl/wlf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlf_pkg
// Types, field widths, status codes and register indexes shared by the
// weight limited fifo and its slot memory.
// ----------------------------------------------------------------------------
package wlf_pkg;

  // field widths
  localparam int MASS_W     = 12;
  localparam int OWNER_W    = 22;
  localparam int STAMP_W    = 64;
  localparam int LOAD_W     = 16;
  localparam int SUM_W      = 16;
  localparam int CNT_W      = 5;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // default slot count
  localparam int DEPTH_DEFAULT = 16;

  // status codes
  localparam logic [STATUS_W-1:0] ST_PUT_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PUT_REJ    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TAKE_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TAKE_HEAVY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TAKE_OK    = 3'd4;

  // command function codes
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_TAKE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL_MASS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES    = 1'd1;

  // register reset values
  localparam logic [SUM_W-1:0] MAX_TOTAL_MASS_RST = 16'hFFFF;
  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST    = 5'd16;

  // command item
  typedef struct packed {
    logic                func;
    logic [MASS_W-1:0]   item_mass;
    logic [OWNER_W-1:0]  owner_id;
    logic [STAMP_W-1:0]  stamp;
    logic [LOAD_W-1:0]   carrier_capacity;
    logic [LOAD_W-1:0]   carrier_load;
  } cmd_t;

  // result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MASS_W-1:0]   out_mass;
    logic [OWNER_W-1:0]  out_owner;
    logic [STAMP_W-1:0]  out_stamp;
    logic [CNT_W-1:0]    held_count;
    logic [SUM_W-1:0]    held_mass;
  } result_t;

  // one stored package
  typedef struct packed {
    logic [MASS_W-1:0]  mass;
    logic [OWNER_W-1:0] owner;
    logic [STAMP_W-1:0] stamp;
  } slot_t;

endpackage

/* hw/rtl/wlf_slot_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlf_slot_ram
// Simple dual port slot memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module wlf_slot_ram #(
  parameter int DEPTH = wlf_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = $bits(wlf_pkg::slot_t)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/weight_limited_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weight_limited_fifo
// Ring-buffer FIFO of packages bounded by an entry limit and a total mass
// limit; a take pops the head only if it fits the taker's spare capacity.
//
// channel   direction  handshake               payload
// command   in         start & !busy           cmd (wlf_pkg::cmd_t)
// result    out        done, one cycle         result (wlf_pkg::result_t)
// config    in         cfg_we                  cfg_index, cfg_data
//
// A put's result shows the cycle after the transfer and busy stays low,
// so a new command may follow at once.
// A take reads the head slot from the slot memory at the transfer edge;
// busy is high in the take state, where that read data is checked.
// Synchronous reset empties the queue and loads the register defaults;
// slot contents are not cleared. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module weight_limited_fifo #(
  parameter int DEPTH = wlf_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  wlf_pkg::cmd_t                       cmd,
  output logic                                done,
  output wlf_pkg::result_t                    result,
  input  logic                                cfg_we,
  input  logic [wlf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wlf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int SW = (PW + 1 > wlf_pkg::CNT_W) ? PW + 1 : wlf_pkg::CNT_W;
  localparam int DW = $bits(wlf_pkg::slot_t);

  // sequencer states
  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_TAKE = 1'b1;

  logic [0:0]                    state, state_next;
  logic [PW-1:0]                 head_ptr, head_ptr_next;
  logic [wlf_pkg::CNT_W-1:0]     entry_count, entry_count_next;
  logic [wlf_pkg::SUM_W-1:0]     mass_sum, mass_sum_next;
  logic [wlf_pkg::SUM_W-1:0]     max_total_mass;
  logic [wlf_pkg::CNT_W-1:0]     max_entries;
  logic [wlf_pkg::LOAD_W-1:0]    take_cap;
  logic [wlf_pkg::LOAD_W-1:0]    take_load;
  logic                          done_next;
  wlf_pkg::result_t              result_next;

  logic                          accept;
  logic                          put_full;
  logic                          put_heavy;
  logic                          put_reject;
  logic [SW-1:0]                 tail_sum;
  logic [PW-1:0]                 tail_ptr;
  logic                          mem_we;
  logic                          mem_re;
  wlf_pkg::slot_t                wr_slot;
  wlf_pkg::slot_t                rd_slot;
  logic [DW-1:0]                 rd_bits;
  logic [wlf_pkg::SUM_W:0]       take_need;

  assign accept = start && !busy;
  assign busy   = (state == S_TAKE);

  // tail = (head + count) mod depth, sum stays below twice the depth
  assign tail_sum = SW'(head_ptr) + SW'(entry_count);
  assign tail_ptr = (tail_sum >= SW'(DEPTH)) ? PW'(tail_sum - SW'(DEPTH)) : PW'(tail_sum);

  // put admission checks
  assign put_full   = (entry_count >= max_entries) || (32'(entry_count) >= 32'(DEPTH));
  assign put_heavy  = ({1'b0, mass_sum} + (wlf_pkg::SUM_W + 1)'(cmd.item_mass))
                      > {1'b0, max_total_mass};
  assign put_reject = (cmd.item_mass == '0) || put_full || put_heavy;

  // slot memory ports
  assign mem_we        = accept && (cmd.func == wlf_pkg::FUNC_PUT) && !put_reject;
  assign mem_re        = accept && (cmd.func == wlf_pkg::FUNC_TAKE);
  assign wr_slot.mass  = cmd.item_mass;
  assign wr_slot.owner = cmd.owner_id;
  assign wr_slot.stamp = cmd.stamp;
  assign rd_slot       = wlf_pkg::slot_t'(rd_bits);

  wlf_slot_ram #(
    .DEPTH (DEPTH),
    .AW    (PW),
    .DW    (DW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail_ptr),
    .wdata (DW'(wr_slot)),
    .re    (mem_re),
    .raddr (head_ptr),
    .rdata (rd_bits)
  );

  // head mass plus current load, full width
  assign take_need = (wlf_pkg::SUM_W + 1)'(rd_slot.mass) + (wlf_pkg::SUM_W + 1)'(take_load);

  // sequencer and queue state update
  always_comb begin
    state_next       = state;
    head_ptr_next    = head_ptr;
    entry_count_next = entry_count;
    mass_sum_next    = mass_sum;
    done_next        = 1'b0;
    result_next      = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd.func == wlf_pkg::FUNC_PUT) begin
            done_next = 1'b1;
            if (put_reject) begin
              result_next.status = wlf_pkg::ST_PUT_REJ;
            end else begin
              result_next.status = wlf_pkg::ST_PUT_OK;
              entry_count_next   = entry_count + 1'b1;
              mass_sum_next      = mass_sum + wlf_pkg::SUM_W'(cmd.item_mass);
            end
          end else begin
            state_next = S_TAKE;
          end
        end
      end
      S_TAKE: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        if (entry_count == '0) begin
          result_next.status = wlf_pkg::ST_TAKE_EMPTY;
        end else if (take_need > {1'b0, take_cap}) begin
          result_next.status = wlf_pkg::ST_TAKE_HEAVY;
        end else begin
          result_next.status    = wlf_pkg::ST_TAKE_OK;
          result_next.out_mass  = rd_slot.mass;
          result_next.out_owner = rd_slot.owner;
          result_next.out_stamp = rd_slot.stamp;
          head_ptr_next    = (head_ptr == PW'(DEPTH - 1)) ? '0 : head_ptr + 1'b1;
          entry_count_next = entry_count - 1'b1;
          mass_sum_next    = (wlf_pkg::SUM_W'(rd_slot.mass) <= mass_sum)
                             ? mass_sum - wlf_pkg::SUM_W'(rd_slot.mass) : '0;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    result_next.held_count = entry_count_next;
    result_next.held_mass  = mass_sum_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head_ptr    <= '0;
      entry_count <= '0;
      mass_sum    <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      head_ptr    <= head_ptr_next;
      entry_count <= entry_count_next;
      mass_sum    <= mass_sum_next;
      done        <= done_next;
    end
  end

  // result and take operand registers
  always_ff @(posedge clk) begin
    result <= result_next;
    if (mem_re) begin
      take_cap  <= cmd.carrier_capacity;
      take_load <= cmd.carrier_load;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_total_mass <= wlf_pkg::MAX_TOTAL_MASS_RST;
      max_entries    <= wlf_pkg::MAX_ENTRIES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wlf_pkg::REG_MAX_TOTAL_MASS: max_total_mass <= cfg_data;
        wlf_pkg::REG_MAX_ENTRIES:    max_entries    <= cfg_data[wlf_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  // busy only follows an accepted take
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    busy |-> $past(start && !busy && (cmd.func == wlf_pkg::FUNC_TAKE)))
    else $error("busy without a take transfer");

  // a take result always comes out of the memory read cycle
  a_take_ok_after_read: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == wlf_pkg::ST_TAKE_OK)) |-> $past(busy))
    else $error("take result without a head read");

  // an accepted put grows the count by one
  a_put_ok_count: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == wlf_pkg::ST_PUT_OK))
      |-> (entry_count == wlf_pkg::CNT_W'($past(entry_count) + 1'b1)))
    else $error("put ok without count increment");

  // a popped head releases one entry
  a_take_ok_count: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == wlf_pkg::ST_TAKE_OK))
      |-> (entry_count == wlf_pkg::CNT_W'($past(entry_count) - 1'b1)))
    else $error("take ok without count decrement");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the weight limited fifo. A scoreboard class mirrors
// the package ring, its entry and mass limits and the carrier weight test. It
// predicts every result from the accepted commands and compares each result
// field by field. A directed opening covers empty takes, zero-mass puts,
// extreme fields, exact and overweight takes and a full queue. Random phases
// then sweep the register settings, including limits lowered below the
// current contents, with and without sender idling.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH         = wlf_pkg::DEPTH_DEFAULT;
  localparam int SETTLE_CYCLES = 4;
  localparam int NUM_PHASES    = 7;

  // scoreboard: mirror of the fifo plus the queue of predicted results
  class fifo_scoreboard;
    wlf_pkg::slot_t   slots[DEPTH];
    int unsigned      head_idx;
    int unsigned      held;
    int unsigned      mass_total;
    int unsigned      mass_cap;
    int unsigned      entry_cap;
    wlf_pkg::result_t pending_results[$];
    int unsigned      errors;

    function new();
      head_idx   = 0;
      held       = 0;
      mass_total = 0;
      mass_cap   = wlf_pkg::MAX_TOTAL_MASS_RST;
      entry_cap  = wlf_pkg::MAX_ENTRIES_RST;
      errors     = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function int unsigned head_mass();
      return (held == 0) ? 0 : slots[head_idx].mass;
    endfunction

    function void set_limits(int unsigned mass_limit, int unsigned entry_limit);
      mass_cap  = mass_limit & 16'hFFFF;
      entry_cap = entry_limit & 5'h1F;
    endfunction

    // work out the result of one command and advance the mirror
    function wlf_pkg::result_t predict(wlf_pkg::cmd_t c);
      wlf_pkg::result_t r;
      int unsigned      limit;
      int unsigned      tail;
      int unsigned      hm;
      r = '0;
      if (c.func == wlf_pkg::FUNC_PUT) begin
        limit = (entry_cap > DEPTH) ? DEPTH : entry_cap;
        if (c.item_mass == 0 || held >= limit || mass_total + c.item_mass > mass_cap) begin
          r.status = wlf_pkg::ST_PUT_REJ;
        end else begin
          tail = (head_idx + held) % DEPTH;
          slots[tail].mass  = c.item_mass;
          slots[tail].owner = c.owner_id;
          slots[tail].stamp = c.stamp;
          held++;
          mass_total += c.item_mass;
          r.status = wlf_pkg::ST_PUT_OK;
        end
      end else if (held == 0) begin
        r.status = wlf_pkg::ST_TAKE_EMPTY;
      end else begin
        hm = slots[head_idx].mass;
        if (hm + c.carrier_load > c.carrier_capacity) begin
          r.status = wlf_pkg::ST_TAKE_HEAVY;
        end else begin
          r.out_mass  = slots[head_idx].mass;
          r.out_owner = slots[head_idx].owner;
          r.out_stamp = slots[head_idx].stamp;
          head_idx    = (head_idx + 1) % DEPTH;
          held--;
          mass_total  = (hm <= mass_total) ? mass_total - hm : 0;
          r.status    = wlf_pkg::ST_TAKE_OK;
        end
      end
      r.held_count = wlf_pkg::CNT_W'(held);
      r.held_mass  = wlf_pkg::SUM_W'(mass_total);
      return r;
    endfunction

    function void note_command(wlf_pkg::cmd_t c);
      pending_results.push_back(predict(c));
    endfunction

    task check_result(wlf_pkg::result_t got);
      wlf_pkg::result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with no command pending, status %0d", got.status));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.out_mass !== want.out_mass)
          report($sformatf("out_mass got %0d want %0d", got.out_mass, want.out_mass));
        if (got.out_owner !== want.out_owner)
          report($sformatf("out_owner got %h want %h", got.out_owner, want.out_owner));
        if (got.out_stamp !== want.out_stamp)
          report($sformatf("out_stamp got %h want %h", got.out_stamp, want.out_stamp));
        if (got.held_count !== want.held_count)
          report($sformatf("held_count got %0d want %0d", got.held_count, want.held_count));
        if (got.held_mass !== want.held_mass)
          report($sformatf("held_mass got %0d want %0d", got.held_mass, want.held_mass));
      end
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  wlf_pkg::cmd_t                  command = '0;
  logic                           done;
  wlf_pkg::result_t               result;
  logic                           cfg_we = 1'b0;
  logic [wlf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wlf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  fifo_scoreboard scoreboard = new();

  weight_limited_fifo #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (command),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result check first, then note any command transfer at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) scoreboard.check_result(result);
      if (start && !busy) scoreboard.note_command(command);
    end
  end

  // hold start until the transfer edge; start stays high for the caller
  task send_cmd(wlf_pkg::cmd_t c);
    start   <= 1'b1;
    command <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task send_put(int unsigned mass, logic [wlf_pkg::OWNER_W-1:0] owner,
                logic [wlf_pkg::STAMP_W-1:0] stamp);
    wlf_pkg::cmd_t c;
    c.func             = wlf_pkg::FUNC_PUT;
    c.item_mass        = wlf_pkg::MASS_W'(mass);
    c.owner_id         = owner;
    c.stamp            = stamp;
    c.carrier_capacity = wlf_pkg::LOAD_W'($urandom);
    c.carrier_load     = wlf_pkg::LOAD_W'($urandom);
    send_cmd(c);
  endtask

  task send_take(int unsigned capacity, int unsigned load);
    wlf_pkg::cmd_t c;
    c.func             = wlf_pkg::FUNC_TAKE;
    c.item_mass        = wlf_pkg::MASS_W'($urandom);
    c.owner_id         = wlf_pkg::OWNER_W'($urandom);
    c.stamp            = {$urandom, $urandom};
    c.carrier_capacity = wlf_pkg::LOAD_W'(capacity);
    c.carrier_load     = wlf_pkg::LOAD_W'(load);
    send_cmd(c);
  endtask

  // drop start and wait until every predicted result has arrived
  task settle();
    start <= 1'b0;
    @(posedge clk);
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both limit registers on back-to-back edges
  task write_limits(int unsigned mass_limit, int unsigned entry_limit);
    cfg_we    <= 1'b1;
    cfg_index <= wlf_pkg::REG_MAX_TOTAL_MASS;
    cfg_data  <= wlf_pkg::CFG_DATA_W'(mass_limit);
    @(posedge clk);
    cfg_index <= wlf_pkg::REG_MAX_ENTRIES;
    cfg_data  <= wlf_pkg::CFG_DATA_W'(entry_limit);
    @(posedge clk);
    cfg_we    <= 1'b0;
    scoreboard.set_limits(mass_limit, entry_limit);
    @(posedge clk);
  endtask

  // random command, with some takes aimed right at the weight boundary
  function wlf_pkg::cmd_t random_cmd(int unsigned put_pct);
    wlf_pkg::cmd_t c;
    int unsigned   pick;
    int unsigned   load;
    int unsigned   hm;
    c.func     = ($urandom_range(0, 99) < put_pct) ? wlf_pkg::FUNC_PUT : wlf_pkg::FUNC_TAKE;
    pick       = $urandom_range(0, 99);
    if (pick < 8) c.item_mass = '0;
    else if (pick < 16) c.item_mass = 12'hFFF;
    else if (pick < 60) c.item_mass = wlf_pkg::MASS_W'($urandom_range(1, 400));
    else c.item_mass = wlf_pkg::MASS_W'($urandom_range(1, 4095));
    c.owner_id = wlf_pkg::OWNER_W'($urandom);
    c.stamp    = {$urandom, $urandom};
    pick       = $urandom_range(0, 99);
    if (pick < 55) begin
      load               = $urandom_range(0, 30000);
      c.carrier_load     = wlf_pkg::LOAD_W'(load);
      c.carrier_capacity = wlf_pkg::LOAD_W'($urandom_range(load + 4095, 65535));
    end else if (pick < 75) begin
      c.carrier_load     = wlf_pkg::LOAD_W'($urandom);
      c.carrier_capacity = wlf_pkg::LOAD_W'($urandom);
    end else begin
      hm                 = scoreboard.head_mass();
      load               = $urandom_range(0, 65535 - hm);
      c.carrier_load     = wlf_pkg::LOAD_W'(load);
      c.carrier_capacity = (hm + load > 0) ?
                           wlf_pkg::LOAD_W'(hm + load - $urandom_range(0, 1)) : '0;
    end
    return c;
  endfunction

  // random phase: put bias swings so the queue fills and drains
  task run_random(int unsigned count, int unsigned idle_pct);
    int unsigned put_pct;
    for (int unsigned n = 0; n < count; n++) begin
      put_pct = ((n / 16) % 2) ? 30 : 75;
      if (n == count / 2 || $urandom_range(0, 59) == 0) begin
        settle();
      end else if ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      send_cmd(random_cmd(put_pct));
    end
  endtask

  // main sequence
  initial begin
    int unsigned mass_limits[NUM_PHASES] = '{65535, 0, 10000, 65535, 20000, 65535, 300};
    int unsigned entry_limits[NUM_PHASES] = '{16, 16, 4, 0, 31, 1, 16};
    int unsigned phase_items[NUM_PHASES] = '{70, 30, 70, 30, 70, 60, 70};
    int unsigned idle_pcts[NUM_PHASES] = '{0, 45, 21, 0, 45, 21, 0};
    int unsigned wait_cycles;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty, zero mass, extreme fields, weight boundary
    send_take(16'hFFFF, 0);
    send_put(0, wlf_pkg::OWNER_W'($urandom), {$urandom, $urandom});
    send_put(12'hFFF, '1, '1);
    send_put(1, '0, '0);
    send_take(0, 0);
    send_take(16'hFFFF, 16'hFFFF);
    send_take(16'hFFFF, 16'hF000);
    send_take(1, 0);
    send_take(5, 5);

    // directed: fill to the entry limit, then one put too many
    for (int i = 0; i < DEPTH; i++)
      send_put(12'hFFF, wlf_pkg::OWNER_W'($urandom), {$urandom, $urandom});
    send_put(1, wlf_pkg::OWNER_W'($urandom), {$urandom, $urandom});

    // random phases; the queue keeps its contents across limit changes
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_limits(mass_limits[p], entry_limits[p]);
      run_random(phase_items[p], idle_pcts[p]);
    end

    // drain, with a bound
    start <= 1'b0;
    wait_cycles = 0;
    while (scoreboard.pending() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (scoreboard.pending() != 0)
      scoreboard.report($sformatf("%0d results never arrived", scoreboard.pending()));

    if (scoreboard.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
